FILE: hdl/qrs_pkg.sv
// shared types and constants of the quadratic root solver
package qrs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COEF_W        = 32;

	localparam logic [1:0] KIND_DOUBLE  = 2'd0;
	localparam logic [1:0] KIND_REAL    = 2'd1;
	localparam logic [1:0] KIND_COMPLEX = 2'd2;
	localparam logic [1:0] KIND_DEGEN   = 2'd3;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
	} coef_t;

	typedef struct packed {
		logic [1:0]               root_kind;
		logic signed [COEF_W-1:0] first_real;
		logic signed [COEF_W-1:0] second_real;
		logic signed [COEF_W-1:0] imag_part;
		logic                     overflow;
	} root_t;

endpackage

FILE: hdl/qrs_sqrt_cell.sv
// one bit step of the pipelined integer square root
module qrs_sqrt_cell #(
	parameter int SW = 49,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*SW-1:0] in_rad,
	input  logic [SW+1:0]   in_rem,
	input  logic [SW-1:0]   in_root,
	input  logic [TW-1:0]   in_side,
	output logic            out_valid,
	output logic [2*SW-1:0] out_rad,
	output logic [SW+1:0]   out_rem,
	output logic [SW-1:0]   out_root,
	output logic [TW-1:0]   out_side
);

	logic [SW+1:0] r2;
	logic [SW+1:0] trial;
	logic          ge;

	always_comb begin
		r2    = {in_rem[SW-1:0], in_rad[2*SW-1 -: 2]};
		trial = {in_root, 2'b01};
		ge    = (r2 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_rad  <= {in_rad[2*SW-3:0], 2'b00};
		out_rem  <= ge ? (r2 - trial) : r2;
		out_root <= {in_root[SW-2:0], ge};
		out_side <= in_side;
	end

endmodule

FILE: hdl/qrs_div_cell.sv
// one bit step of two restoring divisions sharing a divisor
module qrs_div_cell #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_den,
	input  logic [NW-1:0] in_num0,
	input  logic [NW-1:0] in_num1,
	input  logic [DW-1:0] in_rem0,
	input  logic [DW-1:0] in_rem1,
	input  logic [NW-1:0] in_quo0,
	input  logic [NW-1:0] in_quo1,
	input  logic [TW-1:0] in_side,
	output logic          out_valid,
	output logic [DW-1:0] out_den,
	output logic [NW-1:0] out_num0,
	output logic [NW-1:0] out_num1,
	output logic [DW-1:0] out_rem0,
	output logic [DW-1:0] out_rem1,
	output logic [NW-1:0] out_quo0,
	output logic [NW-1:0] out_quo1,
	output logic [TW-1:0] out_side
);

	logic [DW:0] r0, r1, d, s0, s1;
	logic        ge0, ge1;

	always_comb begin
		r0  = {in_rem0, in_num0[NW-1]};
		r1  = {in_rem1, in_num1[NW-1]};
		d   = {1'b0, in_den};
		ge0 = (r0 >= d);
		ge1 = (r1 >= d);
		s0  = ge0 ? (r0 - d) : r0;
		s1  = ge1 ? (r1 - d) : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_den  <= in_den;
		out_num0 <= {in_num0[NW-2:0], 1'b0};
		out_num1 <= {in_num1[NW-2:0], 1'b0};
		out_rem0 <= s0[DW-1:0];
		out_rem1 <= s1[DW-1:0];
		out_quo0 <= {in_quo0[NW-2:0], ge0};
		out_quo1 <= {in_quo1[NW-2:0], ge1};
		out_side <= in_side;
	end

endmodule

FILE: hdl/quadratic_root_solver_core.sv
// quadratic root solver: exact discriminant, root cell chain, divider cell chain
// pipeline of 3 front stages,
// 33 + FRAC_BITS square root cells, 34 + FRAC_BITS divider cells, 1 output register
// throughput one transaction per cycle; busy stays low and results cannot be stalled
// asynchronous reset clears all valid bits; payload registers are not reset
module quadratic_root_solver_core #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  qrs_pkg::coef_t operands,
	output logic          done,
	output qrs_pkg::root_t result
);

	localparam int SW  = 33 + FRAC_BITS;
	localparam int NW  = 34 + FRAC_BITS;
	localparam int DW  = 33;
	localparam int FW  = 5;
	localparam int STW = FW + 32 + NW;
	localparam int XW  = NW + 2;

	// front stage 1: magnitudes
	logic        v_s1, na_s1, nb_s1, nc_s1;
	logic [31:0] ma_s1, mb_s1, mc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		na_s1 <= operands.coef_a[31];
		nb_s1 <= operands.coef_b[31];
		nc_s1 <= operands.coef_c[31];
		ma_s1 <= operands.coef_a[31] ? -operands.coef_a : operands.coef_a;
		mb_s1 <= operands.coef_b[31] ? -operands.coef_b : operands.coef_b;
		mc_s1 <= operands.coef_c[31] ? -operands.coef_c : operands.coef_c;
	end

	// front stage 2: products
	logic        v_s2, na_s2, nb_s2, sac_s2;
	logic [31:0] ma_s2, mb_s2;
	logic [63:0] b2_s2, ac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		na_s2  <= na_s1;
		nb_s2  <= nb_s1;
		sac_s2 <= na_s1 ^ nc_s1;
		ma_s2  <= ma_s1;
		mb_s2  <= mb_s1;
		b2_s2  <= 64'(mb_s1) * 64'(mb_s1);
		ac_s2  <= 64'(ma_s1) * 64'(mc_s1);
	end

	// front stage 3: discriminant
	logic signed [66:0] disc;
	logic        [NW-1:0] cnum;
	logic        v_s3;
	logic [65:0] dmag_s3;
	logic [STW-1:0] side_s3;

	always_comb begin
		if (sac_s2) begin
			disc = 67'(b2_s2) + 67'({ac_s2, 2'b00});
		end else begin
			disc = 67'(b2_s2) - 67'({ac_s2, 2'b00});
		end
		cnum = (NW'(mb_s2) << FRAC_BITS) + NW'(ma_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dmag_s3 <= disc[66] ? 66'(-disc) : disc[65:0];
		side_s3 <= {(ma_s2 == 32'd0), disc[66], (disc == 67'sd0), na_s2,
			!(na_s2 ^ nb_s2), ma_s2, cnum};
	end

	// square root cell chain
	logic            sq_v    [SW+1];
	logic [2*SW-1:0] sq_rad  [SW+1];
	logic [SW+1:0]   sq_rem  [SW+1];
	logic [SW-1:0]   sq_root [SW+1];
	logic [STW-1:0]  sq_side [SW+1];

	assign sq_v[0]    = v_s3;
	assign sq_rad[0]  = {dmag_s3, {(2*FRAC_BITS){1'b0}}};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s3;

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		qrs_sqrt_cell #(.SW(SW), .TW(STW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_v[i]),
			.in_rad   (sq_rad[i]),
			.in_rem   (sq_rem[i]),
			.in_root  (sq_root[i]),
			.in_side  (sq_side[i]),
			.out_valid(sq_v[i+1]),
			.out_rad  (sq_rad[i+1]),
			.out_rem  (sq_rem[i+1]),
			.out_root (sq_root[i+1]),
			.out_side (sq_side[i+1])
		);
	end

	// divider cell chain: lane 0 offset, lane 1 centre
	logic [31:0]   sq_ma;
	logic          dv_v    [NW+1];
	logic [DW-1:0] dv_den  [NW+1];
	logic [NW-1:0] dv_num0 [NW+1];
	logic [NW-1:0] dv_num1 [NW+1];
	logic [DW-1:0] dv_rem0 [NW+1];
	logic [DW-1:0] dv_rem1 [NW+1];
	logic [NW-1:0] dv_quo0 [NW+1];
	logic [NW-1:0] dv_quo1 [NW+1];
	logic [FW-1:0] dv_side [NW+1];

	assign sq_ma      = sq_side[SW][NW +: 32];
	assign dv_v[0]    = sq_v[SW];
	assign dv_den[0]  = {sq_ma, 1'b0};
	assign dv_num0[0] = NW'(sq_root[SW]) + NW'(sq_ma);
	assign dv_num1[0] = sq_side[SW][NW-1:0];
	assign dv_rem0[0] = '0;
	assign dv_rem1[0] = '0;
	assign dv_quo0[0] = '0;
	assign dv_quo1[0] = '0;
	assign dv_side[0] = sq_side[SW][STW-1 -: FW];

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(.NW(NW), .DW(DW), .TW(FW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_v[j]),
			.in_den   (dv_den[j]),
			.in_num0  (dv_num0[j]),
			.in_num1  (dv_num1[j]),
			.in_rem0  (dv_rem0[j]),
			.in_rem1  (dv_rem1[j]),
			.in_quo0  (dv_quo0[j]),
			.in_quo1  (dv_quo1[j]),
			.in_side  (dv_side[j]),
			.out_valid(dv_v[j+1]),
			.out_den  (dv_den[j+1]),
			.out_num0 (dv_num0[j+1]),
			.out_num1 (dv_num1[j+1]),
			.out_rem0 (dv_rem0[j+1]),
			.out_rem1 (dv_rem1[j+1]),
			.out_quo0 (dv_quo0[j+1]),
			.out_quo1 (dv_quo1[j+1]),
			.out_side (dv_side[j+1])
		);
	end

	// result assembly
	function automatic logic [32:0] sat32(input logic signed [XW-1:0] v);
		logic [32:0] r;
		if (v > XW'(signed'(33'sh0_7FFF_FFFF))) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < XW'(signed'(33'sh1_8000_0000))) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic                 f_azero, f_dneg, f_dzero, f_noff, f_ncen;
	logic signed [XW-1:0] cen, off;
	logic [32:0]          sat_c, sat_p, sat_m, sat_o;
	qrs_pkg::root_t       res;

	assign {f_azero, f_dneg, f_dzero, f_noff, f_ncen} = dv_side[NW];

	always_comb begin
		cen   = f_ncen ? -XW'(dv_quo1[NW]) : XW'(dv_quo1[NW]);
		off   = f_noff ? -XW'(dv_quo0[NW]) : XW'(dv_quo0[NW]);
		sat_c = sat32(cen);
		sat_p = sat32(cen + off);
		sat_m = sat32(cen - off);
		sat_o = sat32(off);
		res   = '0;
		if (f_azero) begin
			res.root_kind = qrs_pkg::KIND_DEGEN;
		end else if (f_dzero) begin
			res.root_kind   = qrs_pkg::KIND_DOUBLE;
			res.first_real  = sat_c[31:0];
			res.second_real = sat_c[31:0];
			res.overflow    = sat_c[32];
		end else if (!f_dneg) begin
			res.root_kind   = qrs_pkg::KIND_REAL;
			res.first_real  = sat_p[31:0];
			res.second_real = sat_m[31:0];
			res.overflow    = sat_p[32] | sat_m[32];
		end else begin
			res.root_kind   = qrs_pkg::KIND_COMPLEX;
			res.first_real  = sat_c[31:0];
			res.second_real = sat_c[31:0];
			res.imag_part   = sat_o[31:0];
			res.overflow    = sat_c[32] | sat_o[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[NW];
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

	assign busy = 1'b0;

endmodule

FILE: hdl/qrs_checker.sv
// port level checks of the quadratic root solver
module qrs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           busy,
	input logic           done,
	input qrs_pkg::root_t result
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.root_kind == qrs_pkg::KIND_DEGEN |->
		result.first_real == 32'sd0 && result.second_real == 32'sd0 &&
		result.imag_part == 32'sd0 && !result.overflow)
		else $error("degenerate transaction carries nonzero fields");

	a_double_root: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.root_kind == qrs_pkg::KIND_DOUBLE |->
		result.first_real == result.second_real && result.imag_part == 32'sd0)
		else $error("double root fields differ");

	a_real_imag: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.root_kind == qrs_pkg::KIND_REAL |-> result.imag_part == 32'sd0)
		else $error("real roots with imaginary part");

	a_complex_pair: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.root_kind == qrs_pkg::KIND_COMPLEX |->
		result.first_real == result.second_real)
		else $error("complex pair real parts differ");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.busy  (busy),
	.done  (done),
	.result(result)
);
